FILE: rtl/core/gcr_sector_payload_encoder_defines.svh
// Assertion macros shared by the sector payload encoder modules.
`ifndef GCR_SECTOR_PAYLOAD_ENCODER_DEFINES_SVH
`define GCR_SECTOR_PAYLOAD_ENCODER_DEFINES_SVH

// Checked on every rising edge outside reset.
`define GCR_SPE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define GCR_SPE_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/gcr_spe_pkg.sv
// Types, constants and the disk code table of the sector payload encoder.
`timescale 1ns / 1ps

package gcr_spe_pkg;

	localparam logic [9:0] LastGroupPos = 10'd523;

	localparam logic [7:0] DiskCode [64] = '{
		8'h96, 8'h97, 8'h9a, 8'h9b, 8'h9d, 8'h9e, 8'h9f, 8'ha6,
		8'ha7, 8'hab, 8'hac, 8'had, 8'hae, 8'haf, 8'hb2, 8'hb3,
		8'hb4, 8'hb5, 8'hb6, 8'hb7, 8'hb9, 8'hba, 8'hbb, 8'hbc,
		8'hbd, 8'hbe, 8'hbf, 8'hcb, 8'hcd, 8'hce, 8'hcf, 8'hd3,
		8'hd6, 8'hd7, 8'hd9, 8'hda, 8'hdb, 8'hdc, 8'hdd, 8'hde,
		8'hdf, 8'he5, 8'he6, 8'he7, 8'he9, 8'hea, 8'heb, 8'hec,
		8'hed, 8'hee, 8'hef, 8'hf2, 8'hf3, 8'hf4, 8'hf5, 8'hf6,
		8'hf7, 8'hf9, 8'hfa, 8'hfb, 8'hfc, 8'hfd, 8'hfe, 8'hff
	};

	// One encoded group; the sums are used only for the sector's last group.
	typedef struct packed {
		logic       last_group;
		logic [7:0] enc_a;
		logic [7:0] enc_b;
		logic [7:0] enc_c;
		logic [7:0] sum_a;
		logic [7:0] sum_b;
		logic [7:0] sum_c;
	} grp_t;

	function automatic logic [5:0] pack_high(input logic [7:0] x, input logic [7:0] y,
			input logic [7:0] z);
		return {x[7:6], y[7:6], z[7:6]};
	endfunction

endpackage

FILE: rtl/core/gcr_spe_front.sv
// Front end: takes payload bytes, keeps the checksums and scrambles complete groups.
`timescale 1ns / 1ps

module gcr_spe_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         data_byte,
	input  logic               start_sector,
	input  logic               q_full,
	output logic               push,
	output gcr_spe_pkg::grp_t  push_grp
);

	localparam logic [1:0] PhFirst  = 2'd0;
	localparam logic [1:0] PhSecond = 2'd1;
	localparam logic [1:0] PhThird  = 2'd2;

	logic [7:0] sum_a_q, sum_b_q, sum_c_q;
	logic [7:0] held_first_q, held_second_q;
	logic [9:0] pos_q;
	logic [1:0] phase_q;

	logic       accept;
	logic [7:0] sa_cur, sb_cur, sc_cur, c_rot;
	logic [9:0] pos_cur;
	logic [1:0] phase_cur;
	logic       is_last;
	logic       completes;
	logic [7:0] op_b, op_c;
	logic [8:0] add_a, add_b, add_c;
	logic [7:0] new_a, new_b, new_c;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		sa_cur    = start_sector ? 8'd0 : sum_a_q;
		sb_cur    = start_sector ? 8'd0 : sum_b_q;
		sc_cur    = start_sector ? 8'd0 : sum_c_q;
		pos_cur   = start_sector ? 10'd0 : pos_q;
		phase_cur = start_sector ? PhFirst : phase_q;
		is_last   = (pos_cur == gcr_spe_pkg::LastGroupPos);
		completes = is_last || (phase_cur == PhThird);
		c_rot     = {sc_cur[6:0], sc_cur[7]};
		op_b      = is_last ? data_byte : held_second_q;
		op_c      = is_last ? 8'd0 : data_byte;
		add_a     = {1'b0, sa_cur} + {1'b0, held_first_q} + {8'd0, c_rot[0]};
		new_a     = add_a[7:0];
		add_b     = {1'b0, sb_cur} + {1'b0, op_b} + {8'd0, add_a[8]};
		new_b     = add_b[7:0];
		add_c     = {1'b0, c_rot} + {1'b0, op_c} + {8'd0, add_b[8]};
		new_c     = is_last ? c_rot : add_c[7:0];
	end

	assign push = accept && completes;

	always_comb begin
		push_grp.last_group = is_last;
		push_grp.enc_a      = held_first_q ^ c_rot;
		push_grp.enc_b      = op_b ^ new_a;
		push_grp.enc_c      = op_c ^ new_b;
		push_grp.sum_a      = new_a;
		push_grp.sum_b      = new_b;
		push_grp.sum_c      = new_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_a_q       <= 8'd0;
			sum_b_q       <= 8'd0;
			sum_c_q       <= 8'd0;
			held_first_q  <= 8'd0;
			held_second_q <= 8'd0;
			pos_q         <= 10'd0;
			phase_q       <= PhFirst;
		end else if (accept) begin
			if (is_last) begin
				sum_a_q       <= 8'd0;
				sum_b_q       <= 8'd0;
				sum_c_q       <= 8'd0;
				held_first_q  <= 8'd0;
				held_second_q <= 8'd0;
				pos_q         <= 10'd0;
				phase_q       <= PhFirst;
			end else begin
				pos_q <= pos_cur + 10'd1;
				case (phase_cur)
					PhFirst: begin
						held_first_q <= data_byte;
						phase_q      <= PhSecond;
						sum_a_q      <= sa_cur;
						sum_b_q      <= sb_cur;
						sum_c_q      <= sc_cur;
					end
					PhSecond: begin
						held_second_q <= data_byte;
						phase_q       <= PhThird;
						sum_a_q       <= sa_cur;
						sum_b_q       <= sb_cur;
						sum_c_q       <= sc_cur;
					end
					default: begin
						phase_q <= PhFirst;
						sum_a_q <= new_a;
						sum_b_q <= new_b;
						sum_c_q <= new_c;
					end
				endcase
			end
		end
	end

endmodule

FILE: rtl/core/gcr_spe_queue.sv
// Short queue of encoded groups between the front end and the nibble emitter.
`timescale 1ns / 1ps

`include "gcr_sector_payload_encoder_defines.svh"

module gcr_spe_queue #(
	parameter int Depth = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  gcr_spe_pkg::grp_t  push_grp,
	output logic               full,
	input  logic               pop,
	output logic               head_valid,
	output gcr_spe_pkg::grp_t  head_grp
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] LastIdx = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

	gcr_spe_pkg::grp_t entry_q [Depth];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_pop;

	assign full       = (count_q == FullCnt);
	assign head_valid = (count_q != '0);
	assign head_grp   = entry_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_grp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LastIdx) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LastIdx) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (push && !do_pop) begin
				count_q <= count_q + CntW'(1);
			end else if (!push && do_pop) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

	`GCR_SPE_ASSERT(a_no_push_full, push |-> !full, "group pushed into a full queue")
	`GCR_SPE_ASSERT(a_count_range, count_q <= FullCnt, "queue count beyond its depth")
	`GCR_SPE_ASSERT(a_pop_nonempty, pop |-> head_valid, "group taken from an empty queue")

endmodule

FILE: rtl/core/gcr_spe_back.sv
// Back end: turns queued groups into disk nibbles and holds the output register.
`timescale 1ns / 1ps

`include "gcr_sector_payload_encoder_defines.svh"

module gcr_spe_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head_valid,
	input  gcr_spe_pkg::grp_t  head_grp,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         nibble,
	output logic               last
);

	localparam logic [2:0] StHigh    = 3'd0;
	localparam logic [2:0] StByteA   = 3'd1;
	localparam logic [2:0] StByteB   = 3'd2;
	localparam logic [2:0] StByteC   = 3'd3;
	localparam logic [2:0] StSumA    = 3'd4;
	localparam logic [2:0] StSumB    = 3'd5;
	localparam logic [2:0] StSumC    = 3'd6;

	logic [2:0] step_q;
	logic       out_valid_q;
	logic [7:0] nibble_q;
	logic       last_q;

	logic       load;
	logic       final_step;
	logic [5:0] six;

	assign load       = head_valid && (!out_valid_q || out_ready);
	assign final_step = head_grp.last_group ? (step_q == StSumC) : (step_q == StByteC);
	assign pop        = load && final_step;

	always_comb begin
		case (step_q)
			StHigh:  six = gcr_spe_pkg::pack_high(head_grp.enc_a, head_grp.enc_b,
					head_grp.enc_c);
			StByteA: six = head_grp.enc_a[5:0];
			StByteB: six = head_grp.enc_b[5:0];
			StByteC: six = head_grp.last_group
					? gcr_spe_pkg::pack_high(head_grp.sum_a, head_grp.sum_b, head_grp.sum_c)
					: head_grp.enc_c[5:0];
			StSumA:  six = head_grp.sum_a[5:0];
			StSumB:  six = head_grp.sum_b[5:0];
			StSumC:  six = head_grp.sum_c[5:0];
			default: six = 6'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= StHigh;
			out_valid_q <= 1'b0;
			last_q      <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				last_q      <= head_grp.last_group && (step_q == StSumC);
				step_q      <= final_step ? StHigh : step_q + 3'd1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
				last_q      <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			nibble_q <= gcr_spe_pkg::DiskCode[six];
		end
	end

	assign out_valid = out_valid_q;
	assign nibble    = nibble_q;
	assign last      = last_q;

	`GCR_SPE_ASSERT_ALWAYS(a_last_has_valid, last_q |-> out_valid_q,
			"last flag raised without a valid nibble")
	`GCR_SPE_ASSERT(a_step_range, step_q <= StSumC, "nibble step out of range")
	`GCR_SPE_ASSERT(a_full_group_steps, (head_valid && !head_grp.last_group) |-> step_q <= StByteC,
			"ordinary group stepped into the checksum nibbles")

endmodule

FILE: rtl/core/gcr_sector_payload_encoder.sv
// Top level of the 6-and-2 GCR sector payload encoder.
// A group is queued when its last byte is accepted; its nibbles then pass to the output
// register. Throughput: one byte per cycle while the group queue has room; nibbles leave
// at one per cycle while the output is ready, so three bytes give four nibbles and the
// last group gives seven. The group queue and the output register set these rates.
// Reset clears the checksums, position, queue and output register; no clearing pass.
`timescale 1ns / 1ps

module gcr_sector_payload_encoder #(
	parameter int QueueDepth = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,  // [7:0] data_byte
	input  logic [0:0] s_tuser,  // [0] start_sector
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,  // [7:0] nibble
	output logic       m_tlast
);

	logic              q_full;
	logic              push;
	gcr_spe_pkg::grp_t push_grp;
	logic              pop;
	logic              head_valid;
	gcr_spe_pkg::grp_t head_grp;

	gcr_spe_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.data_byte    (s_tdata),
		.start_sector (s_tuser[0]),
		.q_full       (q_full),
		.push         (push),
		.push_grp     (push_grp)
	);

	gcr_spe_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_grp   (push_grp),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_grp   (head_grp)
	);

	gcr_spe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_grp   (head_grp),
		.pop        (pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.nibble     (m_tdata),
		.last       (m_tlast)
	);

endmodule

FILE: bench/gcr_spe_checker.sv
// Checker that predicts the encoded nibble stream and compares it with the output channel.
`timescale 1ns / 1ps

module gcr_spe_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	input  logic       s_tready,
	input  logic [7:0] s_tdata,
	input  logic [0:0] s_tuser,
	input  logic       m_tvalid,
	input  logic       m_tready,
	input  logic [7:0] m_tdata,
	input  logic       m_tlast,
	output int         failures,
	output int         awaited
);

	localparam logic [9:0] SectorBytes = 10'd524;

	typedef struct packed {
		logic [7:0] code;
		logic       last;
	} disk_nibble_t;

	logic [7:0] sum_a, sum_b, sum_c;
	logic [7:0] held_first, held_second;
	logic [9:0] byte_pos;
	disk_nibble_t nibble_q[$];
	int fail_count = 0;

	task automatic clear_sector();
		sum_a = 8'h00;
		sum_b = 8'h00;
		sum_c = 8'h00;
		held_first = 8'h00;
		held_second = 8'h00;
		byte_pos = 10'd0;
	endtask

	task automatic emit(input logic [5:0] six, input logic last);
		disk_nibble_t n;
		n.code = gcr_spe_pkg::DiskCode[six];
		n.last = last;
		nibble_q.push_back(n);
	endtask

	// The short group has no third byte: it adds nothing to sum_c and emits no
	// nibble of its own, but its scrambled zero still fills the packed nibble.
	task automatic encode_group(input logic [7:0] a, input logic [7:0] b, input logic [7:0] c,
			input logic short_group);
		logic [8:0] sa, sb, sc;
		logic [7:0] ea, eb, ec;
		sum_c = {sum_c[6:0], sum_c[7]};
		sa = sum_a + a + sum_c[0];
		sum_a = sa[7:0];
		ea = a ^ sum_c;
		sb = sum_b + b + sa[8];
		sum_b = sb[7:0];
		eb = b ^ sum_a;
		if (!short_group) begin
			sc = sum_c + c + sb[8];
			sum_c = sc[7:0];
			ec = c ^ sum_b;
		end else begin
			ec = sum_b;
		end
		emit({ea[7:6], eb[7:6], ec[7:6]}, 1'b0);
		emit(ea[5:0], 1'b0);
		emit(eb[5:0], 1'b0);
		if (!short_group)
			emit(ec[5:0], 1'b0);
	endtask

	task automatic take_byte(input logic [7:0] b, input logic start);
		logic [9:0] pos;
		if (start)
			clear_sector();
		pos = byte_pos;
		if (pos >= SectorBytes)
			pos = 10'd0;
		if (pos == gcr_spe_pkg::LastGroupPos) begin
			encode_group(held_first, b, 8'h00, 1'b1);
			emit({sum_a[7:6], sum_b[7:6], sum_c[7:6]}, 1'b0);
			emit(sum_a[5:0], 1'b0);
			emit(sum_b[5:0], 1'b0);
			emit(sum_c[5:0], 1'b1);
			clear_sector();
		end else begin
			case (pos % 3)
				0: held_first = b;
				1: held_second = b;
				default: encode_group(held_first, held_second, b, 1'b0);
			endcase
			byte_pos = pos + 10'd1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		disk_nibble_t want;
		if (!arst_n) begin
			clear_sector();
			nibble_q.delete();
		end else begin
			if (s_tvalid && s_tready)
				take_byte(s_tdata, s_tuser[0]);
			if (m_tvalid && m_tready) begin
				if (nibble_q.size() == 0) begin
					$error("nibble: expected none, actual %h (last %b)", m_tdata, m_tlast);
					fail_count++;
				end else begin
					want = nibble_q.pop_front();
					if (m_tdata !== want.code) begin
						$error("nibble: expected %h, actual %h", want.code, m_tdata);
						fail_count++;
					end
					if (m_tlast !== want.last) begin
						$error("last: expected %b, actual %b", want.last, m_tlast);
						fail_count++;
					end
				end
			end
		end
		failures <= fail_count;
		awaited <= nibble_q.size();
	end

endmodule

FILE: bench/tb.sv
// Top of the sector payload encoder testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'h00;
	logic [0:0] s_tuser = 1'b0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic       m_tlast;
	int         failures;
	int         awaited;
	bit         calm = 1'b0;
	int         idle_odds = 4;

	initial begin
		forever #1 clk = ~clk;
	end

	gcr_sector_payload_encoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	gcr_spe_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.failures(failures),
		.awaited(awaited)
	);

	function automatic logic [7:0] pick_byte(input bit biased);
		if (biased && $urandom_range(0, 1) == 0)
			return ($urandom_range(0, 1) == 0) ? 8'hff : 8'h00;
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic start);
		if (!calm && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= start;
		do @(posedge clk); while (!s_tready);
	endtask

	// A run of bytes; noisy runs may raise the start flag at random points.
	task automatic send_run(input int length, input logic start_first, input bit biased,
			input bit noisy);
		for (int i = 0; i < length; i++) begin
			if (i == 0)
				send_byte(pick_byte(biased), start_first);
			else
				send_byte(pick_byte(biased), noisy && $urandom_range(0, 29) == 0);
		end
	endtask

	initial begin
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 9) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end else if (!calm && $urandom_range(0, 49) == 0) begin
				m_tready <= 1'b1;
				repeat ($urandom_range(20, 200)) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_byte(8'hff, 1'b1);
		send_byte(8'hff, 1'b0);
		send_byte(8'hff, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h7f, 1'b1);
		send_byte(8'h01, 1'b0);
		send_byte(8'h55, 1'b0);
		send_byte(8'haa, 1'b1);

		// The first 424 bytes of a sector; the calm run below ends it, and the next starts with no flag.
		idle_odds = $urandom_range(2, 6);
		send_run(300, 1'b1, 1'b1, 1'b0);
		idle_odds = $urandom_range(0, 5);
		send_run(124, 1'b0, 1'b0, 1'b0);

		calm = 1'b1;
		send_run(100, 1'b0, 1'b0, 1'b0);
		send_run(6, 1'b0, 1'b0, 1'b0);
		s_tvalid <= 1'b0;

		@(posedge clk);
		while (awaited != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (failures == 0 && awaited == 0)
			$display("gcr_sector_payload_encoder regression: pass");
		else
			$display("gcr_sector_payload_encoder regression: fail");
		$finish;
	end

	initial begin
		#2000000;
		$display("gcr_sector_payload_encoder regression: fail");
		$finish;
	end

endmodule
